// ----- design/bns_pkg.sv -----
// ----------------------------------------------------------------------------
// bns_pkg
// shared types, widths and constants of the boid neighbour steering block
// ----------------------------------------------------------------------------
package bns_pkg;

  // neighbour limit per run and derived tally width
  localparam int MAX_NEIGHBOURS = 64;
  localparam int TALLY_W        = $clog2(MAX_NEIGHBOURS + 1);

  // field widths
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int RAD_W   = 31;
  localparam int COS_W   = 16;
  localparam int DIR_W   = 16;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 32;

  // internal arithmetic widths
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int DOT_W   = 51;
  localparam int RHS_W   = 49;
  localparam int QUOT_W  = 41;
  localparam int TERM_W  = QUOT_W + 1;
  localparam int REP_W   = 48;
  localparam int PSUM_W  = 40;
  localparam int VEC_W   = 49;
  localparam int NORM_W  = 30;

  // iteration counts of the square root and divider units
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);
  localparam int FRAC_BITS  = 40;
  localparam int DIR_FRAC   = 15;
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);
  localparam logic [QUOT_W-1:0] DIR_MAX = QUOT_W'(32767);

  // queue between front and back
  localparam int QDEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER   = 3'd0,
    CFG_SEP_RAD = 3'd1,
    CFG_SEP_COS = 3'd2,
    CFG_COH_RAD = 3'd3,
    CFG_COH_COS = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [RAD_W-1:0] INNER_RST   = 31'd98304;
  localparam logic [RAD_W-1:0] SEP_RAD_RST = 31'd327680;
  localparam logic [COS_W-1:0] SEP_COS_RST = 16'hA581;
  localparam logic [RAD_W-1:0] COH_RAD_RST = 31'd589824;
  localparam logic [COS_W-1:0] COH_COS_RST = 16'hECCD;

  typedef struct packed {
    logic [RAD_W-1:0] inner;
    logic [RAD_W-1:0] sep_rad;
    logic [COS_W-1:0] sep_cos;
    logic [RAD_W-1:0] coh_rad;
    logic [COS_W-1:0] coh_cos;
  } cfg_t;

  // one input item, index 0 is x
  typedef struct packed {
    logic [2:0][POS_W-1:0]  self;
    logic [2:0][HEAD_W-1:0] heading;
    logic [2:0][POS_W-1:0]  nb;
    logic                   is_self;
    logic                   last;
  } item_t;

  // classified neighbour handed from front to back
  typedef struct packed {
    logic                   pass_sep;
    logic                   pass_coh;
    logic                   last;
    logic [2:0][TERM_W-1:0] term;
    logic [2:0][POS_W-1:0]  nb;
    logic [2:0][POS_W-1:0]  self;
  } entry_t;

  // one result
  typedef struct packed {
    logic [2:0][DIR_W-1:0] sep;
    logic [2:0][DIR_W-1:0] coh;
    logic [CNT_W-1:0]      sep_cnt;
    logic [CNT_W-1:0]      coh_cnt;
  } result_t;

endpackage

// ----- design/boid_neighbour_steering.sv -----
// ----------------------------------------------------------------------------
// boid_neighbour_steering
// separation and cohesion steering over a list of neighbours
// ----------------------------------------------------------------------------
// Input items are pushed like writes to a queue: one neighbour with the own
// position and heading per transfer (push while full is low). The item that
// carries last_entry closes the run; its result is popped like a queue read
// (empty low, pop). Configuration registers are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// The front takes one item at a time and holds full high until it has
// pushed the entry: it squares the three axis distances and the three
// radii, then runs the 32 step square root with its wait state and the
// cone tests. A neighbour inside the separation test with nonzero distance
// adds three divisions. The back adds each neighbour to the sums as it
// pops it; after the last one it normalises both vectors with its own
// square root and divider, then moves the result into the output register.
// A stalled reader holds the result; the back then waits with the next run
// and a two entry queue lets the front keep classifying meanwhile.
// Reset loads the register defaults and clears sums, tallies and queues.
// ----------------------------------------------------------------------------
module boid_neighbour_steering import bns_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [POS_W-1:0]     self_x_i,
  input  logic [POS_W-1:0]     self_y_i,
  input  logic [POS_W-1:0]     self_z_i,
  input  logic [HEAD_W-1:0]    heading_x_i,
  input  logic [HEAD_W-1:0]    heading_y_i,
  input  logic [HEAD_W-1:0]    heading_z_i,
  input  logic [POS_W-1:0]     neighbour_x_i,
  input  logic [POS_W-1:0]     neighbour_y_i,
  input  logic [POS_W-1:0]     neighbour_z_i,
  input  logic                 is_self_i,
  input  logic                 last_entry_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [DIR_W-1:0]     separation_x_o,
  output logic [DIR_W-1:0]     separation_y_o,
  output logic [DIR_W-1:0]     separation_z_o,
  output logic [DIR_W-1:0]     cohesion_x_o,
  output logic [DIR_W-1:0]     cohesion_y_o,
  output logic [DIR_W-1:0]     cohesion_z_o,
  output logic [CNT_W-1:0]     separation_count_o,
  output logic [CNT_W-1:0]     cohesion_count_o
);

  cfg_t    cfg_q;
  item_t   item;
  entry_t  f_entry;
  entry_t  b_entry;
  result_t result;
  logic    f_push;
  logic    q_full;
  logic    q_empty;
  logic    b_pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner   <= INNER_RST;
      cfg_q.sep_rad <= SEP_RAD_RST;
      cfg_q.sep_cos <= SEP_COS_RST;
      cfg_q.coh_rad <= COH_RAD_RST;
      cfg_q.coh_cos <= COH_COS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_INNER:   cfg_q.inner   <= cfg_data_i[RAD_W-1:0];
        CFG_SEP_RAD: cfg_q.sep_rad <= cfg_data_i[RAD_W-1:0];
        CFG_SEP_COS: cfg_q.sep_cos <= cfg_data_i[COS_W-1:0];
        CFG_COH_RAD: cfg_q.coh_rad <= cfg_data_i[RAD_W-1:0];
        CFG_COH_COS: cfg_q.coh_cos <= cfg_data_i[COS_W-1:0];
        default: ;
      endcase
    end
  end

  // input item
  assign item.self    = {self_z_i, self_y_i, self_x_i};
  assign item.heading = {heading_z_i, heading_y_i, heading_x_i};
  assign item.nb      = {neighbour_z_i, neighbour_y_i, neighbour_x_i};
  assign item.is_self = is_self_i;
  assign item.last    = last_entry_i;

  bns_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .item_i    (item),
    .full_o    (full),
    .q_push_o  (f_push),
    .q_entry_o (f_entry),
    .q_full_i  (q_full)
  );

  bns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_entry),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (b_entry),
    .empty_o (q_empty)
  );

  bns_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_entry_i (b_entry),
    .q_pop_o   (b_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result)
  );

  // result fields
  assign separation_x_o     = result.sep[0];
  assign separation_y_o     = result.sep[1];
  assign separation_z_o     = result.sep[2];
  assign cohesion_x_o       = result.coh[0];
  assign cohesion_y_o       = result.coh[1];
  assign cohesion_z_o       = result.coh[2];
  assign separation_count_o = result.sep_cnt;
  assign cohesion_count_o   = result.coh_cnt;

endmodule

// ----- design/bns_isqrt.sv -----
// ----------------------------------------------------------------------------
// bns_isqrt
// floor square root of a 64 bit value, one result bit per step
// ----------------------------------------------------------------------------
module bns_isqrt import bns_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   value_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  logic                  busy_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]       rem_q;
  logic [SQ_W-1:0]       res_q;
  logic [SQ_W-1:0]       bit_q;
  logic [SQ_W-1:0]       trial;
  logic                  fits;

  // trial subtraction of the current bit pair
  assign trial = res_q + bit_q;
  assign fits  = rem_q >= trial;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= SQRT_CNT_W'(SQRT_STEPS);
    end else if (busy_q) begin
      busy_q <= cnt_q != SQRT_CNT_W'(1);
      cnt_q  <= cnt_q - SQRT_CNT_W'(1);
    end
  end

  // remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// ----- design/bns_fdiv.sv -----
// ----------------------------------------------------------------------------
// bns_fdiv
// fractional restoring divider, floor(num * 2^steps / den) for num <= den
// ----------------------------------------------------------------------------
module bns_fdiv import bns_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SQ_W-1:0]      num_i,
  input  logic [SQ_W-1:0]      den_i,
  input  logic [DIV_CNT_W-1:0] steps_i,
  output logic                 busy_o,
  output logic [QUOT_W-1:0]    quot_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]      rem_q;
  logic [SQ_W-1:0]      den_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [SQ_W:0]        shifted;
  logic                 fits;
  logic                 fits0;

  // integer part on start, one fraction bit per cycle after
  assign fits0   = num_i >= den_i;
  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= steps_i != '0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      busy_q <= cnt_q != DIV_CNT_W'(1);
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= fits0 ? num_i - den_i : num_i;
      quot_q <= QUOT_W'(fits0);
    end else if (busy_q) begin
      rem_q  <= fits ? SQ_W'(shifted - {1'b0, den_q}) : shifted[SQ_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ----- design/bns_fifo.sv -----
// ----------------------------------------------------------------------------
// bns_fifo
// short queue of classified neighbours between front and back
// ----------------------------------------------------------------------------
module bns_fifo import bns_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   empty_o
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);

  entry_t            mem_q [QDEPTH];
  logic [PTR_W-1:0]  wr_q;
  logic [PTR_W-1:0]  rd_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = fill_q == FILL_W'(QDEPTH);
  assign empty_o = fill_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- design/bns_front.sv -----
// ----------------------------------------------------------------------------
// bns_front
// takes one neighbour, runs both neighbourhood tests and the repulsion division
// ----------------------------------------------------------------------------
module bns_front import bns_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   push_i,
  input  item_t  item_i,
  output logic   full_o,
  output logic   q_push_o,
  output entry_t q_entry_o,
  input  logic   q_full_i
);

  typedef enum logic [3:0] {
    F_IDLE, F_SQ, F_ROOT, F_ROOTW, F_CONE, F_TEST, F_DIV, F_DIVW, F_PUSH
  } fstate_e;

  // steps of the squaring sequence
  localparam logic [2:0] SQ_LAST_AXIS = 3'd2;
  localparam logic [2:0] SQ_INNER     = 3'd3;
  localparam logic [2:0] SQ_SEP       = 3'd4;
  localparam logic [2:0] SQ_COH       = 3'd5;

  fstate_e                 state_q;
  logic [2:0]              idx_q;
  logic [2:0][DIFF_W-1:0]  d_q;
  logic [2:0][HEAD_W-1:0]  h_q;
  logic [2:0][POS_W-1:0]   self_q;
  logic [2:0][POS_W-1:0]   nb_q;
  logic                    is_self_q;
  logic                    last_q;
  logic [SQ_W-1:0]         dsq_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [SQ_W-1:0]         in2_q;
  logic [SQ_W-1:0]         sep2_q;
  logic [SQ_W-1:0]         coh2_q;
  logic [ROOT_W-1:0]       root_q;
  logic signed [RHS_W-1:0] rhs_sep_q;
  logic signed [RHS_W-1:0] rhs_coh_q;
  logic                    pass_sep_q;
  logic                    pass_coh_q;
  logic [2:0][TERM_W-1:0]  term_q;

  logic                    accept;
  logic [1:0]              ax;
  logic signed [DIFF_W-1:0] d_sel;
  logic [POS_W-1:0]        d_mag;
  logic [POS_W-1:0]        mul_a;
  logic [SQ_W-1:0]         prod;
  logic [SQ_W:0]           dsq_sum;
  logic signed [RHS_W-1:0] hd;
  logic                    in_hit;
  logic                    sep_ok;
  logic                    coh_ok;
  logic                    sqrt_busy;
  logic [ROOT_W-1:0]       sqrt_root;
  logic                    div_busy;
  logic [QUOT_W-1:0]       div_quot;
  logic [TERM_W-1:0]       quot_ext;

  assign full_o   = state_q != F_IDLE;
  assign accept   = push_i && !full_o;
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;

  // selected axis and its magnitude
  assign ax    = idx_q[1:0];
  assign d_sel = $signed(d_q[ax]);
  assign d_mag = d_sel[DIFF_W-1] ? POS_W'(-d_sel) : POS_W'(d_sel);

  // squaring multiplier: axis distances, then the three radii
  always_comb begin
    case (idx_q)
      SQ_INNER: mul_a = {1'b0, cfg_i.inner};
      SQ_SEP:   mul_a = {1'b0, cfg_i.sep_rad};
      SQ_COH:   mul_a = {1'b0, cfg_i.coh_rad};
      default:  mul_a = d_mag;
    endcase
  end
  assign prod    = mul_a * mul_a;
  assign dsq_sum = {1'b0, dsq_q} + {1'b0, prod};
  assign hd      = $signed(h_q[ax]) * d_sel;

  // neighbourhood tests
  assign in_hit = dsq_q < in2_q;
  assign sep_ok = in_hit || (!(dsq_q > sep2_q) && (dot_q > DOT_W'(rhs_sep_q)));
  assign coh_ok = in_hit || (!(dsq_q > coh2_q) && (dot_q > DOT_W'(rhs_coh_q)));

  assign quot_ext = {1'b0, div_quot};

  bns_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == F_ROOT),
    .value_i (dsq_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  bns_fdiv u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == F_DIV),
    .num_i   (SQ_W'(d_mag)),
    .den_i   (dsq_q),
    .steps_i (DIV_CNT_W'(FRAC_BITS)),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          idx_q <= '0;
          if (accept) state_q <= F_SQ;
        end
        F_SQ: begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == SQ_COH) state_q <= F_ROOT;
        end
        F_ROOT:  state_q <= F_ROOTW;
        F_ROOTW: if (!sqrt_busy) state_q <= F_CONE;
        F_CONE:  state_q <= F_TEST;
        F_TEST: begin
          idx_q   <= '0;
          state_q <= (!is_self_q && sep_ok && dsq_q != '0) ? F_DIV : F_PUSH;
        end
        F_DIV:   state_q <= F_DIVW;
        F_DIVW: begin
          if (!div_busy) begin
            if (idx_q == SQ_LAST_AXIS) begin
              state_q <= F_PUSH;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= F_DIV;
            end
          end
        end
        F_PUSH: if (!q_full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            d_q[i] <= $signed({item_i.nb[i][POS_W-1], item_i.nb[i]})
                    - $signed({item_i.self[i][POS_W-1], item_i.self[i]});
          end
          h_q       <= item_i.heading;
          self_q    <= item_i.self;
          nb_q      <= item_i.nb;
          is_self_q <= item_i.is_self;
          last_q    <= item_i.last;
          dsq_q     <= '0;
          dot_q     <= '0;
        end
      end
      F_SQ: begin
        case (idx_q)
          SQ_INNER: in2_q  <= prod;
          SQ_SEP:   sep2_q <= prod;
          SQ_COH:   coh2_q <= prod;
          default: begin
            // saturating distance square and heading dot product
            dsq_q <= dsq_sum[SQ_W] ? '1 : dsq_sum[SQ_W-1:0];
            dot_q <= dot_q + DOT_W'(hd);
          end
        endcase
      end
      F_ROOTW: root_q <= sqrt_root;
      F_CONE: begin
        rhs_sep_q <= $signed(cfg_i.sep_cos) * $signed({1'b0, root_q});
        rhs_coh_q <= $signed(cfg_i.coh_cos) * $signed({1'b0, root_q});
      end
      F_TEST: begin
        pass_sep_q <= !is_self_q && sep_ok;
        pass_coh_q <= !is_self_q && coh_ok;
        term_q     <= '0;
      end
      F_DIVW: begin
        // repulsion points away from the neighbour
        if (!div_busy) begin
          term_q[ax] <= (!d_sel[DIFF_W-1] && d_sel != '0)
                      ? TERM_W'(-$signed(quot_ext)) : quot_ext;
        end
      end
      default: ;
    endcase
  end

  // queue entry
  always_comb begin
    q_entry_o          = '0;
    q_entry_o.pass_sep = pass_sep_q;
    q_entry_o.pass_coh = pass_coh_q;
    q_entry_o.last     = last_q;
    q_entry_o.term     = term_q;
    q_entry_o.nb       = nb_q;
    q_entry_o.self     = self_q;
  end

endmodule

// ----- design/bns_back.sv -----
// ----------------------------------------------------------------------------
// bns_back
// accumulates classified neighbours and normalises both sums at run end
// ----------------------------------------------------------------------------
module bns_back import bns_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  entry_t  q_entry_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t result_o
);

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_MAG, B_SHIFT, B_SQ, B_ROOT, B_ROOTW, B_DIV, B_DIVW,
    B_NEXT, B_EMIT
  } bstate_e;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  bstate_e                state_q;
  logic [2:0][REP_W-1:0]  rep_sum_q;
  logic [2:0][PSUM_W-1:0] psum_q;
  logic [TALLY_W-1:0]     rtally_q;
  logic [TALLY_W-1:0]     ctally_q;
  logic [1:0]             idx_q;
  logic                   which_q;
  logic                   res_valid_q;
  result_t                res_q;

  logic [2:0][POS_W-1:0]  self_q;
  logic [2:0][VEC_W-1:0]  sep_vec_q;
  logic [2:0][VEC_W-1:0]  coh_vec_q;
  logic [TALLY_W-1:0]     sep_n_q;
  logic [TALLY_W-1:0]     coh_n_q;
  logic [2:0][VEC_W-1:0]  mag_q;
  logic [2:0]             neg_q;
  logic [SQ_W-1:0]        sq_q;
  logic [ROOT_W-1:0]      len_q;
  logic [2:0][DIR_W-1:0]  sep_dir_q;
  logic [2:0][DIR_W-1:0]  coh_dir_q;

  logic                   take;
  logic                   add_sep;
  logic                   add_coh;
  logic                   res_free;
  logic                   emit;
  logic                   big;
  logic [2:0][VEC_W-1:0]  vec_sel;
  logic [TALLY_W-1:0]     n_sel;
  logic [2:0][VEC_W-1:0]  coh_c;
  logic [SQ_W-1:0]        sq_term;
  logic                   sqrt_busy;
  logic [ROOT_W-1:0]      sqrt_root;
  logic                   div_busy;
  logic [QUOT_W-1:0]      div_quot;
  logic [DIR_W-1:0]       q_clamp;
  logic [DIR_W-1:0]       dir_val;

  // saturating repulsion sum
  function automatic logic [REP_W-1:0] sat_rep(logic [REP_W-1:0] a, logic [TERM_W-1:0] b);
    logic [REP_W:0] s;
    s = {a[REP_W-1], a} + {{(REP_W + 1 - TERM_W){b[TERM_W-1]}}, b};
    if (s[REP_W] != s[REP_W-1]) begin
      return s[REP_W] ? {1'b1, {(REP_W - 1){1'b0}}} : {1'b0, {(REP_W - 1){1'b1}}};
    end
    return s[REP_W-1:0];
  endfunction

  // saturating position sum
  function automatic logic [PSUM_W-1:0] sat_pos(logic [PSUM_W-1:0] a, logic [POS_W-1:0] b);
    logic [PSUM_W:0] s;
    s = {a[PSUM_W-1], a} + {{(PSUM_W + 1 - POS_W){b[POS_W-1]}}, b};
    if (s[PSUM_W] != s[PSUM_W-1]) begin
      return s[PSUM_W] ? {1'b1, {(PSUM_W - 1){1'b0}}} : {1'b0, {(PSUM_W - 1){1'b1}}};
    end
    return s[PSUM_W-1:0];
  endfunction

  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign take     = q_pop_o;
  assign add_sep  = q_entry_i.pass_sep && (rtally_q < TALLY_W'(MAX_NEIGHBOURS));
  assign add_coh  = q_entry_i.pass_coh && (ctally_q < TALLY_W'(MAX_NEIGHBOURS));
  assign res_free = !res_valid_q || pop_i;
  assign emit     = (state_q == B_EMIT) && res_free;
  assign empty_o  = !res_valid_q;
  assign result_o = res_q;

  // centroid offset: position sum minus count times own position
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [VEC_W-1:0] cp;
      cp = $signed({1'b0, ctally_q}) * $signed(self_q[i]);
      coh_c[i] = $signed({{(VEC_W - PSUM_W){psum_q[i][PSUM_W-1]}}, psum_q[i]}) - cp;
    end
  end

  // vector under normalisation
  assign vec_sel = which_q ? coh_vec_q : sep_vec_q;
  assign n_sel   = which_q ? coh_n_q : sep_n_q;
  assign big     = (mag_q[0][VEC_W-1:NORM_W] != '0) || (mag_q[1][VEC_W-1:NORM_W] != '0)
                || (mag_q[2][VEC_W-1:NORM_W] != '0);
  assign sq_term = mag_q[idx_q][NORM_W-1:0] * mag_q[idx_q][NORM_W-1:0];

  // clamped, signed direction component
  assign q_clamp = (div_quot > DIR_MAX) ? DIR_MAX[DIR_W-1:0] : div_quot[DIR_W-1:0];
  assign dir_val = neg_q[idx_q] ? (~q_clamp + DIR_W'(1)) : q_clamp;

  bns_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == B_ROOT),
    .value_i (sq_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  bns_fdiv u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == B_DIV) && (len_q != '0)),
    .num_i   (SQ_W'(mag_q[idx_q][NORM_W-1:0])),
    .den_i   (SQ_W'(len_q)),
    .steps_i (DIV_CNT_W'(DIR_FRAC)),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // sequencer, sums and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rep_sum_q   <= '0;
      psum_q      <= '0;
      rtally_q    <= '0;
      ctally_q    <= '0;
      idx_q       <= '0;
      which_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (take) begin
            if (add_sep) begin
              for (int i = 0; i < 3; i++) begin
                rep_sum_q[i] <= sat_rep(rep_sum_q[i], q_entry_i.term[i]);
              end
              rtally_q <= rtally_q + TALLY_W'(1);
            end
            if (add_coh) begin
              for (int i = 0; i < 3; i++) begin
                psum_q[i] <= sat_pos(psum_q[i], q_entry_i.nb[i]);
              end
              ctally_q <= ctally_q + TALLY_W'(1);
            end
            if (q_entry_i.last) state_q <= B_LOAD;
          end
        end
        B_LOAD: begin
          rep_sum_q <= '0;
          psum_q    <= '0;
          rtally_q  <= '0;
          ctally_q  <= '0;
          which_q   <= 1'b0;
          state_q   <= B_MAG;
        end
        B_MAG:   state_q <= (n_sel == '0) ? B_NEXT : B_SHIFT;
        B_SHIFT: begin
          idx_q <= '0;
          if (!big) state_q <= B_SQ;
        end
        B_SQ: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == LAST_AXIS) state_q <= B_ROOT;
        end
        B_ROOT:  state_q <= B_ROOTW;
        B_ROOTW: begin
          idx_q <= '0;
          if (!sqrt_busy) state_q <= B_DIV;
        end
        B_DIV: begin
          if (len_q != '0) begin
            state_q <= B_DIVW;
          end else if (idx_q == LAST_AXIS) begin
            state_q <= B_NEXT;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        B_DIVW: begin
          if (!div_busy) begin
            if (idx_q == LAST_AXIS) begin
              state_q <= B_NEXT;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= B_DIV;
            end
          end
        end
        B_NEXT: begin
          if (!which_q) begin
            which_q <= 1'b1;
            state_q <= B_MAG;
          end else begin
            state_q <= B_EMIT;
          end
        end
        B_EMIT: if (res_free) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // normalisation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (take) self_q <= q_entry_i.self;
      B_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          sep_vec_q[i] <= {rep_sum_q[i][REP_W-1], rep_sum_q[i]};
        end
        coh_vec_q <= coh_c;
        sep_n_q   <= rtally_q;
        coh_n_q   <= ctally_q;
      end
      B_MAG: begin
        if (n_sel == '0) begin
          if (which_q) coh_dir_q <= '0;
          else sep_dir_q <= '0;
        end
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= vec_sel[i][VEC_W-1];
          mag_q[i] <= vec_sel[i][VEC_W-1] ? VEC_W'(-$signed(vec_sel[i])) : vec_sel[i];
        end
        sq_q <= '0;
      end
      B_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end
      end
      B_SQ:    sq_q <= sq_q + sq_term;
      B_ROOTW: len_q <= sqrt_root;
      B_DIV: begin
        // zero length leaves a zero direction
        if (len_q == '0) begin
          if (which_q) coh_dir_q[idx_q] <= '0;
          else sep_dir_q[idx_q] <= '0;
        end
      end
      B_DIVW: begin
        if (!div_busy) begin
          if (which_q) coh_dir_q[idx_q] <= dir_val;
          else sep_dir_q[idx_q] <= dir_val;
        end
      end
      B_EMIT: begin
        if (res_free) begin
          res_q.sep     <= sep_dir_q;
          res_q.coh     <= coh_dir_q;
          res_q.sep_cnt <= CNT_W'(sep_n_q);
          res_q.coh_cnt <= CNT_W'(coh_n_q);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/bns_checker.sv -----
// ----------------------------------------------------------------------------
// bns_checker
// port level checks of the boid neighbour steering block
// ----------------------------------------------------------------------------
module bns_checker import bns_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [DIR_W-1:0] separation_x_o,
  input logic [DIR_W-1:0] separation_y_o,
  input logic [DIR_W-1:0] separation_z_o,
  input logic [DIR_W-1:0] cohesion_x_o,
  input logic [DIR_W-1:0] cohesion_y_o,
  input logic [DIR_W-1:0] cohesion_z_o,
  input logic [CNT_W-1:0] separation_count_o,
  input logic [CNT_W-1:0] cohesion_count_o
);

  localparam bit CNT_EXACT = MAX_NEIGHBOURS < (1 << CNT_W);

  // an accepted item keeps the front busy in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front took a second item right after a transfer");

  // a waiting result holds until it is popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(separation_x_o) && $stable(cohesion_z_o)
      && $stable(separation_count_o) && $stable(cohesion_count_o)))
    else $error("result changed while stalled");

  // counts never exceed the neighbour limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!CNT_EXACT || (separation_count_o <= CNT_W'(MAX_NEIGHBOURS)
      && cohesion_count_o <= CNT_W'(MAX_NEIGHBOURS))))
    else $error("neighbour count above limit");

  // no neighbour gives a zero direction
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && CNT_EXACT) |->
      ((separation_count_o != '0 || (separation_x_o == '0 && separation_y_o == '0
        && separation_z_o == '0)) && (cohesion_count_o != '0 || (cohesion_x_o == '0
        && cohesion_y_o == '0 && cohesion_z_o == '0))))
    else $error("direction nonzero with zero count");

endmodule

bind boid_neighbour_steering bns_checker u_bns_checker (.*);
